// File: src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Types and constants shared by the timer expiry queue modules.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int TIME_W    = 48;
    localparam int PER_W     = 32;
    localparam int SLOT_W    = 6;   // covers up to 64 timers
    localparam int MAX_EXP   = 16;  // expired timers handled per check
    localparam int CNT_EXP_W = 5;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_EXPIRE = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;

    // Cell operation codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_LATCH = 3'd3;
    localparam logic [2:0] OP_PICK  = 3'd4;
    localparam logic [2:0] OP_REARM = 3'd5;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0]        timer_id;
        logic [TIME_W-1:0] expire_at;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] now_time;
    } teq_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        slot;
        logic              earliest_changed;
        logic [TIME_W-1:0] next_expire;
        logic              next_valid;
        logic              last;
    } teq_out_t;

    // Broadcast to every cell
    typedef struct packed {
        logic [2:0]        code;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] expiry;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] now_time;
        logic              due_mode;
    } teq_op_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] val;
        logic [SLOT_W-1:0] slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } teq_tok_t;

endpackage

// File: src/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// One timer slot: holds expiry, period and flags, and refines the search
// token passed along the chain.
// ----------------------------------------------------------------------------
module teq_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  teq_pkg::teq_op_t  op,
    input  teq_pkg::teq_tok_t tok_in,
    output teq_pkg::teq_tok_t tok_out,
    output logic              live_o
);
    import teq_pkg::*;

    logic              live_reg;
    logic              due_reg;
    logic              picked_reg;
    logic [TIME_W-1:0] exp_reg;
    logic [PER_W-1:0]  per_reg;
    teq_tok_t          tok_reg;
    teq_tok_t          tok_next;

    logic              hit;
    logic              elig;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] rearm_val;

    assign hit       = (op.slot == SLOT_W'(IDX));
    assign elig      = op.due_mode ? (due_reg && !picked_reg) : live_reg;
    assign sum       = {1'b0, op.now_time} + {{(TIME_W+1-PER_W){1'b0}}, per_reg};
    assign rearm_val = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_comb begin
        tok_next = tok_in;
        if (elig && (!tok_in.found || exp_reg < tok_in.val)) begin
            tok_next.found = 1'b1;
            tok_next.val   = exp_reg;
            tok_next.slot  = SLOT_W'(IDX);
        end
        if (!tok_in.free_found && !live_reg) begin
            tok_next.free_found = 1'b1;
            tok_next.free_slot  = SLOT_W'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= 1'b0;
            due_reg    <= 1'b0;
            picked_reg <= 1'b0;
            tok_reg    <= '0;
        end else begin
            tok_reg <= tok_next;
            case (op.code)
                OP_WRITE: begin
                    if (hit) begin
                        live_reg <= 1'b1;
                        exp_reg  <= op.expiry;
                        per_reg  <= op.period;
                    end
                end
                OP_CLEAR: begin
                    if (hit) live_reg <= 1'b0;
                end
                OP_LATCH: begin
                    due_reg    <= live_reg && (exp_reg <= op.now_time);
                    picked_reg <= 1'b0;
                end
                OP_PICK: begin
                    if (hit) picked_reg <= 1'b1;
                end
                OP_REARM: begin
                    if (picked_reg) begin
                        if (per_reg != '0) exp_reg <= rearm_val;
                        else live_reg <= 1'b0;
                    end
                    picked_reg <= 1'b0;
                    due_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign tok_out = tok_reg;
    assign live_o  = live_reg;

endmodule

// File: src/timer_expiry_queue_unit.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue_unit
// Timer table ordered by expiry: add, cancel and expire check, built as a
// chain of slot cells with a search token walking the chain.
// ----------------------------------------------------------------------------
//  channel | ports                      | carries
//  --------+----------------------------+------------------------------------
//  input   | s_valid s_ready s_payload  | command transaction (teq_in_t)
//  output  | m_valid m_ready m_payload  | result transaction (teq_out_t)
//
// Flow: every search walks the token through all TIMERS cells (S_SCAN).
//   Each command passes an accept state (S_IDLE) and a setup state (S_OP)
//   before its searches. Add, cancel and unused commands take one search;
//   an expire check with n due timers takes n+2 searches and then emits one
//   result per expired timer plus a final result, as the output allows.
// Reset: synchronous, active low; clears all live flags, no clearing pass.
// Stalls: one command is in flight at a time; a result waits in the output
//   register, and an add holds its write, but cancel and expire still update state.
// ----------------------------------------------------------------------------
module timer_expiry_queue_unit #(
    parameter int TIMERS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  teq_pkg::teq_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output teq_pkg::teq_out_t m_payload
);
    import teq_pkg::*;

    localparam int CNT_W = $clog2(TIMERS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]         state_reg;
    teq_in_t            in_reg;
    logic               mode_reg;      // 1: search among due timers
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_EXP_W-1:0] n_reg;
    logic [CNT_EXP_W-1:0] k_reg;
    logic [SLOT_W-1:0]  order_reg [MAX_EXP];
    logic [TIME_W-1:0]  nexp_reg;
    logic               nvalid_reg;
    logic               m_valid_reg;
    teq_out_t           m_payload_reg;
    logic               in_reg_cancel_ok;

    teq_op_t            op;
    teq_tok_t           tok [TIMERS+1];
    logic [TIMERS-1:0]  live_vec;
    teq_tok_t           res;

    logic               out_free;
    logic               cancel_hit;
    logic               changed;
    logic               emit;
    teq_out_t           cmd_res;

    assign out_free = !m_valid_reg || m_ready;
    assign res      = tok[TIMERS];
    assign tok[0]   = '0;

    // Cancel only touches an existing, live slot
    assign cancel_hit = (32'(in_reg.timer_id) < 32'(TIMERS))
                        && live_vec[$clog2(TIMERS)'(in_reg.timer_id)];
    assign changed    = !res.found || (in_reg.expire_at < res.val);

    // A result transaction is loaded this cycle
    assign emit = out_free && ((state_reg == S_EVAL && in_reg.cmd != CMD_EXPIRE)
                               || state_reg == S_EMIT);

    generate
        for (genvar g = 0; g < TIMERS; g++) begin : g_cell
            teq_cell #(.IDX(g)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .op      (op),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1]),
                .live_o  (live_vec[g])
            );
        end
    endgenerate

    // Broadcast operation for the cells
    always_comb begin
        op          = '0;
        op.code     = OP_NONE;
        op.expiry   = in_reg.expire_at;
        op.period   = in_reg.period;
        op.now_time = in_reg.now_time;
        op.due_mode = mode_reg;
        op.slot     = SLOT_W'(in_reg.timer_id);
        case (state_reg)
            S_OP: begin
                if (in_reg.cmd == CMD_CANCEL && cancel_hit) op.code = OP_CLEAR;
                else if (in_reg.cmd == CMD_EXPIRE) op.code = OP_LATCH;
            end
            S_EVAL: begin
                if (in_reg.cmd == CMD_ADD) begin
                    if (res.free_found && out_free) begin
                        op.code = OP_WRITE;
                        op.slot = res.free_slot;
                    end
                end else if (in_reg.cmd == CMD_EXPIRE && mode_reg) begin
                    if (res.found && 32'(n_reg) < MAX_EXP) begin
                        op.code = OP_PICK;
                        op.slot = res.slot;
                    end else begin
                        op.code = OP_REARM;
                    end
                end
            end
            default: ;
        endcase
    end

    // Single result for add, cancel and unused commands
    always_comb begin
        cmd_res             = '0;
        cmd_res.last        = 1'b1;
        cmd_res.next_expire = res.found ? res.val : '0;
        cmd_res.next_valid  = res.found;
        case (in_reg.cmd)
            CMD_ADD: begin
                if (res.free_found) begin
                    cmd_res.status           = ST_ADDED;
                    cmd_res.slot             = res.free_slot[3:0];
                    cmd_res.earliest_changed = changed;
                    cmd_res.next_expire      = changed ? in_reg.expire_at : res.val;
                    cmd_res.next_valid       = 1'b1;
                end else begin
                    cmd_res.status = ST_FULL;
                end
            end
            CMD_CANCEL: begin
                // the clear already happened before this search
                cmd_res.status = in_reg_cancel_ok ? ST_CANCELLED : ST_NOT_FOUND;
                cmd_res.slot   = in_reg.timer_id;
            end
            default: begin
                cmd_res.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_payload;
                        state_reg <= S_OP;
                    end
                end
                S_OP: begin
                    mode_reg  <= (in_reg.cmd == CMD_EXPIRE);
                    n_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    // token passes through the register of every cell before S_EVAL
                    if (cnt_reg == CNT_W'(TIMERS - 1)) state_reg <= S_EVAL;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                S_EVAL: begin
                    if (in_reg.cmd == CMD_EXPIRE) begin
                        cnt_reg <= '0;
                        if (mode_reg) begin
                            state_reg <= S_SCAN;
                            if (res.found && 32'(n_reg) < MAX_EXP) begin
                                order_reg[n_reg[CNT_EXP_W-2:0]] <= res.slot;
                                n_reg <= n_reg + 1'b1;
                            end else begin
                                mode_reg <= 1'b0;
                            end
                        end else begin
                            nexp_reg   <= res.found ? res.val : '0;
                            nvalid_reg <= res.found;
                            k_reg      <= '0;
                            state_reg  <= S_EMIT;
                        end
                    end else if (out_free) begin
                        m_payload_reg <= cmd_res;
                        state_reg     <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_payload_reg.status      <= ST_EXPIRED;
                        m_payload_reg.earliest_changed <= 1'b0;
                        m_payload_reg.next_expire <= nexp_reg;
                        m_payload_reg.next_valid  <= nvalid_reg;
                        if (k_reg < n_reg) begin
                            m_payload_reg.slot <= order_reg[k_reg[CNT_EXP_W-2:0]][3:0];
                            m_payload_reg.last <= 1'b0;
                            k_reg              <= k_reg + 1'b1;
                        end else begin
                            m_payload_reg.slot <= '0;
                            m_payload_reg.last <= 1'b1;
                            state_reg          <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The cancel outcome is decided in S_OP, before the live flag is cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg_cancel_ok <= 1'b0;
        end else if (state_reg == S_OP) begin
            in_reg_cancel_ok <= cancel_hit;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_nexp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.next_valid |-> m_payload.next_expire == '0)
        else $error("next_expire nonzero with nothing pending");

    a_changed_add: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.earliest_changed |-> m_payload.status == ST_ADDED)
        else $error("earliest_changed outside an add");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != ST_EXPIRED |-> m_payload.last)
        else $error("non-expire result without last");

    a_expire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(n_reg) <= MAX_EXP)
        else $error("expired count overflow");

endmodule
